// File: rtl/csrmv_pkg.sv
// Shared types and constants for the CSR sparse matrix-vector unit.
package csrmv_pkg;

    localparam int COL_W  = 10;
    localparam int DATA_W = 32;
    localparam int ROW_W  = 16;
    localparam int ACC_W  = 64;

    typedef logic [1:0] t_func;

    localparam t_func FUNC_LOAD    = 2'd0;
    localparam t_func FUNC_NONZERO = 2'd1;
    localparam t_func FUNC_ROW_END = 2'd2;

    typedef struct packed {
        logic  valid;
        t_func func;
    } t_op;

endpackage

// File: rtl/csrmv_vec_store.sv
// Dense vector store: one write port, one registered read port.
module csrmv_vec_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [AW-1:0]                     i_wr_addr,
    input  logic [csrmv_pkg::DATA_W-1:0]      i_wr_data,
    input  logic                              i_rd_en,
    input  logic [AW-1:0]                     i_rd_addr,
    output logic [csrmv_pkg::DATA_W-1:0]      o_rd_data
);

    logic [csrmv_pkg::DATA_W-1:0] mem [DEPTH];
    logic [csrmv_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/csrmv_mac.sv
// Multiply stage, saturating accumulator, row clamp and result register.
module csrmv_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  csrmv_pkg::t_op                       i_s1_op,
    input  logic signed [csrmv_pkg::DATA_W-1:0]  i_s1_value,
    input  logic signed [csrmv_pkg::DATA_W-1:0]  i_s1_x,
    input  logic                                 i_out_stall,
    output logic                                 o_adv,
    output logic                                 o_out_valid,
    output logic signed [csrmv_pkg::DATA_W-1:0]  o_row_sum,
    output logic [csrmv_pkg::ROW_W-1:0]          o_row_number,
    output logic                                 o_saturated
);

    localparam int AW1 = csrmv_pkg::ACC_W + 1;

    csrmv_pkg::t_op                       r_s2_op;
    logic signed [csrmv_pkg::ACC_W-1:0]   r_s2_prod;
    logic signed [csrmv_pkg::ACC_W-1:0]   r_acc;
    logic signed [csrmv_pkg::ACC_W-1:0]   n_acc;
    logic [csrmv_pkg::ROW_W-1:0]          r_row;
    logic                                 r_out_valid;
    logic signed [csrmv_pkg::DATA_W-1:0]  r_row_sum;
    logic [csrmv_pkg::ROW_W-1:0]          r_row_number;
    logic                                 r_saturated;

    logic signed [csrmv_pkg::ACC_W-1:0]   prod_sh;
    logic [AW1-1:0]                       sum_ext;
    logic                                 out_free;
    logic                                 is_row_end;
    logic                                 is_nonzero;
    logic                                 clip;
    logic signed [csrmv_pkg::DATA_W-1:0]  clamped;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign is_row_end = r_s2_op.valid && (r_s2_op.func == csrmv_pkg::FUNC_ROW_END);
    assign is_nonzero = r_s2_op.valid && (r_s2_op.func == csrmv_pkg::FUNC_NONZERO);
    assign o_adv      = !(is_row_end && !out_free);

    // floor shift of the product, then saturating 64-bit add
    assign prod_sh = r_s2_prod >>> FRAC_BITS;
    assign sum_ext = {r_acc[csrmv_pkg::ACC_W-1], r_acc}
                   + {prod_sh[csrmv_pkg::ACC_W-1], prod_sh};

    always_comb begin
        if (sum_ext[AW1-1] != sum_ext[AW1-2]) begin
            n_acc = sum_ext[AW1-1] ? {1'b1, {(csrmv_pkg::ACC_W-1){1'b0}}}
                                   : {1'b0, {(csrmv_pkg::ACC_W-1){1'b1}}};
        end else begin
            n_acc = sum_ext[csrmv_pkg::ACC_W-1:0];
        end
    end

    // clip the accumulator to the 32-bit range
    assign clip = !((&r_acc[csrmv_pkg::ACC_W-1:csrmv_pkg::DATA_W-1])
                 || !(|r_acc[csrmv_pkg::ACC_W-1:csrmv_pkg::DATA_W-1]));

    always_comb begin
        if (clip) begin
            clamped = r_acc[csrmv_pkg::ACC_W-1] ? {1'b1, {(csrmv_pkg::DATA_W-1){1'b0}}}
                                                : {1'b0, {(csrmv_pkg::DATA_W-1){1'b1}}};
        end else begin
            clamped = r_acc[csrmv_pkg::DATA_W-1:0];
        end
    end

    // payload of stage two and the result register
    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_s2_prod <= i_s1_value * i_s1_x;
            if (is_row_end) begin
                r_row_sum    <= clamped;
                r_row_number <= r_row;
                r_saturated  <= clip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_op     <= '0;
            r_acc       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_adv) begin
                r_s2_op <= i_s1_op;
            end
            if (o_adv && is_row_end) begin
                r_acc       <= '0;
                r_row       <= r_row + csrmv_pkg::ROW_W'(1);
                r_out_valid <= 1'b1;
            end else begin
                if (o_adv && is_nonzero) begin
                    r_acc <= n_acc;
                end
                if (r_out_valid && !i_out_stall) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_row_sum    = r_row_sum;
    assign o_row_number = r_row_number;
    assign o_saturated  = r_saturated;

endmodule

// File: rtl/csr_sparse_matvec_top.sv
// Top level of the streaming CSR sparse matrix-vector unit.
//
// Computes y = A*x in signed Q16.16. Load the dense vector first (func load,
// column = index, value = element), then stream the nonzeros of each row
// (func nonzero, column, value) and close every row with a row-end item,
// which yields one result: the row sum clipped to 32 bits, the row number and
// a flag set when clipping took place. An empty row yields zero. The unit
// takes one item per clock cycle when input is not held off; a row sum enters
// the result register once its row-end item passes the read and multiply
// stages. The pipeline is: vector store read, multiply (one 32x32 product),
// both registered, then shift-and-accumulate or clamp. Input is held off
// only when a row end reaches the last stage while the result register still
// holds a row sum that the sink stalls. A load writes the store at its own
// transfer, so a nonzero right behind it reads the new element with no
// forwarding. The store has no clearing pass and is usable straight after
// reset; only columns loaded earlier may be referenced. A load at a column
// not below VEC_DEPTH is dropped, and a nonzero there counts as zero.
module csr_sparse_matvec_top #(
    parameter int VEC_DEPTH = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [1:0]                           i_func,
    input  logic [csrmv_pkg::COL_W-1:0]          i_column,
    input  logic signed [csrmv_pkg::DATA_W-1:0]  i_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [csrmv_pkg::DATA_W-1:0]  o_row_sum,
    output logic [csrmv_pkg::ROW_W-1:0]          o_row_number,
    output logic                                 o_saturated
);

    localparam int AW    = $clog2(VEC_DEPTH);
    localparam int EXT_W = AW + csrmv_pkg::COL_W + 1;

    logic                                 adv;
    logic                                 in_xfer;
    logic                                 in_range;
    logic [EXT_W-1:0]                     col_ext;
    logic [AW-1:0]                        addr;
    logic [csrmv_pkg::DATA_W-1:0]         rd_data;
    logic signed [csrmv_pkg::DATA_W-1:0]  s1_x;

    csrmv_pkg::t_op                       r_s1_op;
    csrmv_pkg::t_op                       n_s1_op;
    logic signed [csrmv_pkg::DATA_W-1:0]  r_s1_value;
    logic                                 r_s1_in_range;

    // The whole pipeline advances together; only a blocked row end halts it.
    assign o_in_stall = !adv;
    assign in_xfer    = i_in_valid && adv;

    // Bound the column against the store depth.
    assign col_ext  = EXT_W'(i_column);
    assign addr     = col_ext[AW-1:0];
    assign in_range = col_ext < EXT_W'(VEC_DEPTH);

    assign n_s1_op.valid = in_xfer;
    assign n_s1_op.func  = i_func;

    csrmv_vec_store #(
        .DEPTH (VEC_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (in_xfer && (i_func == csrmv_pkg::FUNC_LOAD) && in_range),
        .i_wr_addr (addr),
        .i_wr_data (i_value),
        .i_rd_en   (adv),
        .i_rd_addr (addr),
        .o_rd_data (rd_data)
    );

    // Stage one: hold the value alongside the read that is in flight.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_value    <= i_value;
            r_s1_in_range <= in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_op <= '0;
        end else if (adv) begin
            r_s1_op <= n_s1_op;
        end
    end

    // An out-of-range column contributes nothing.
    assign s1_x = r_s1_in_range ? rd_data : '0;

    csrmv_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s1_op      (r_s1_op),
        .i_s1_value   (r_s1_value),
        .i_s1_x       (s1_x),
        .i_out_stall  (i_out_stall),
        .o_adv        (adv),
        .o_out_valid  (o_out_valid),
        .o_row_sum    (o_row_sum),
        .o_row_number (o_row_number),
        .o_saturated  (o_saturated)
    );

    // Input is held off only behind a full, stalled result register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // A clipped row sum sits at one of the 32-bit limits.
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_row_sum == 32'sh7fffffff || o_row_sum == 32'sh80000000))
        else $error("saturated flag with an unclipped row sum");

    // No result straight after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule
